### rtl/integer_to_ascii_radix_assert.svh
// Assertion macros for the checker file of the integer to text block.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define ITOAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoar assertion failed");

// Next-cycle implication, disabled in reset
`define ITOAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoar assertion failed");

`endif

### rtl/itoar_pkg.sv
// Package of the integer to text block: widths, character codes, types, glyph function.
`timescale 1ns / 1ps

package itoar_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int INDEX_WIDTH = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET   = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = RADIX_WIDTH'(36);

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX_DECIMAL = DIGIT_WIDTH'(9);
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_LETTER_BASE = DIGIT_WIDTH'(10);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_LOAD
   } state_type;

   // Result of the shared divider towards the sequencer
   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [DIGIT_WIDTH-1:0] remainder;
   } div_result_type;

   // Digit value to its ASCII glyph
   function automatic logic [CHAR_WIDTH-1:0] glyph(input logic [DIGIT_WIDTH-1:0] d);
      logic [DIGIT_WIDTH-1:0] off;
      off = d - DIGIT_LETTER_BASE;
      if (d > DIGIT_MAX_DECIMAL) begin
         return CHAR_LOWER_A + CHAR_WIDTH'(off);
      end
      return CHAR_ZERO + CHAR_WIDTH'(d);
   endfunction

endpackage

### rtl/itoar_divider.sv
// Restoring divider, one quotient bit per cycle, for a value by the radix.
`timescale 1ns / 1ps

module itoar_divider
   import itoar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_WIDTH-1:0] divisor,
   output div_result_type         result
);

   localparam logic [INDEX_WIDTH-1:0] LAST_STEP = INDEX_WIDTH'(VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [INDEX_WIDTH-1:0] step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGIT_WIDTH:0]   trial;
   logic                   fits;

   // One trial subtraction per cycle
   always_comb begin
      trial    = {rem_ff, shift_ff[VALUE_WIDTH-1]};
      fits     = trial >= {1'b0, divisor};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], fits};
         rem_in   = fits ? DIGIT_WIDTH'(trial - {1'b0, divisor}) : trial[DIGIT_WIDTH-1:0];
         step_in  = step_ff + INDEX_WIDTH'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = shift_ff;
   assign result.remainder = rem_ff;

endmodule

### rtl/integer_to_ascii_radix.sv
// Top level of the integer to text converter: sequencer, digit store and output register.
`timescale 1ns / 1ps

// Converts one 32-bit integer per transaction into its text in the radix held in the csr
// register (2 to 36; smaller settings act as 2, larger as 36), one character per response
// transaction, most significant first, is_last on the final one. In radix ten a negative
// value is led by '-'; other radices read the value as unsigned. Digits come from one
// shared bit-serial divider. Each digit is then read from the digit store and loaded,
// a minus is loaded before them, and the block returns to idle before the next
// acceptance. A stalled response holds the sequencer while the next character waits.
// req_stall is high from acceptance until the last character has been loaded into the
// output register. The csr register should be written only while the block is idle.
module integer_to_ascii_radix
   import itoar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_WIDTH-1:0]  rsp_character,
   output logic                   rsp_is_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_WIDTH-1:0] csr_radix
);

   state_type              state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0] base_ff, base_in;
   logic                   negative_ff, negative_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [DIGIT_WIDTH-1:0] store [VALUE_WIDTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;
   logic [COUNT_WIDTH-1:0] count_less;

   logic                   accept;
   logic                   out_free;
   logic                   div_start;
   logic                   store_we;
   logic                   load_sign;
   logic                   load_digit;
   logic [RADIX_WIDTH-1:0] eff_radix;
   logic                   value_neg;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [VALUE_WIDTH-1:0] div_dividend;
   div_result_type         div_result;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Clamp the configured radix into the usable range
   always_comb begin
      priority if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   // Sign handling: only radix ten shows a minus
   assign value_neg    = (eff_radix == RADIX_DECIMAL) && req_value[VALUE_WIDTH-1];
   assign magnitude    = value_neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign div_dividend = accept ? magnitude : div_result.quotient;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_result.done && (div_result.quotient == '0)) begin
               state_in = negative_ff ? ST_SIGN : ST_READ;
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = (count_ff == COUNT_WIDTH'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall  = 1'b1;
      csr_ready  = 1'b0;
      div_start  = 1'b0;
      store_we   = 1'b0;
      load_sign  = 1'b0;
      load_digit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            csr_ready = !reset;
            div_start = accept;
         end
         ST_DIVIDE: begin
            store_we  = div_result.done;
            div_start = div_result.done && (div_result.quotient != '0);
         end
         ST_SIGN: begin
            load_sign = out_free;
         end
         ST_READ: begin
         end
         ST_LOAD: begin
            load_digit = out_free;
         end
         default: begin
         end
      endcase
   end

   // Register next values
   always_comb begin
      radix_in     = radix_ff;
      base_in      = base_ff;
      negative_in  = negative_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (csr_valid && csr_ready) radix_in = csr_radix;
      if (accept) begin
         base_in     = eff_radix;
         negative_in = value_neg;
         count_in    = '0;
      end else if (store_we) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (load_digit) begin
         count_in = count_less;
      end
      priority if (load_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end else if (load_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = glyph(rd_data_ff);
         rsp_last_in  = (count_ff == COUNT_WIDTH'(1));
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_less = count_ff - COUNT_WIDTH'(1);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         negative_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         negative_ff  <= negative_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit store, least significant digit first, registered read
   always_ff @(posedge clock) begin
      if (store_we) store[count_ff[INDEX_WIDTH-1:0]] <= div_result.remainder;
      rd_data_ff <= store[count_less[INDEX_WIDTH-1:0]];
   end

   itoar_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (accept ? eff_radix : base_ff),
      .result   (div_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

endmodule

### rtl/integer_to_ascii_radix_checker.sv
// Port-level checker for the integer to text converter, with its bind.
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_assert.svh"

module integer_to_ascii_radix_checker
   import itoar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CHAR_WIDTH-1:0] rsp_character,
   input logic                  rsp_is_last
);

   logic                rsp_wait;
   logic                rsp_done;
   logic [CHAR_WIDTH:0] rsp_payload;
   logic                char_ok;

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_done    = rsp_valid && !rsp_stall;
   assign rsp_payload = {rsp_is_last, rsp_character};

   // Legal characters: digits, lower-case letters or a minus
   assign char_ok = (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE) ||
                    (rsp_character >= CHAR_LOWER_A && rsp_character <= CHAR_LOWER_Z) ||
                    (rsp_character == CHAR_MINUS);

   // A held response keeps its character and flag
   `ITOAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_payload))

   // The block is busy right after taking a transaction
   `ITOAR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // Only digits, lower-case letters or a minus appear
   `ITOAR_ASSERT_IMPL(a_char_legal, clock, reset, rsp_valid, char_ok)

   // A minus always has digits after it
   `ITOAR_ASSERT_IMPL(a_minus_not_last, clock, reset, rsp_valid && (rsp_character == CHAR_MINUS), !rsp_is_last)

   // Nothing follows the final character straight away
   `ITOAR_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_done && rsp_is_last, !rsp_valid)

endmodule

bind integer_to_ascii_radix integer_to_ascii_radix_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_is_last   (rsp_is_last)
);
